### sv/fpae_pkg.sv
// ----------------------------------------------------------------------------
// fpae_pkg: shared types and constants of the face pose angle estimator
// Angle limits, sine series constants and the pipeline depth of one arcsine cell.
// ----------------------------------------------------------------------------
package fpae_pkg;

  localparam int COORD_BITS_DEF = 12;

  // arcsine search code counts 1/512 degree, 16 bits wide
  localparam int          H_BITS    = 16;
  localparam logic [15:0] HALF_MAX  = 16'd46080;
  localparam logic [15:0] ANGLE_MAX = 16'd23040;

  // 1/512 degree in radians, Q46
  localparam logic [31:0] RAD_PER_HALF = 32'd2398762259;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;

  // Taylor terms of the sine after the first: divisors (2k)(2k+1) and 2^32/divisor
  localparam int N_TERMS = 8;
  localparam logic [8:0] TERM_DIV [N_TERMS] = '{
    9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
  };
  localparam logic [29:0] TERM_RECIP [N_TERMS] = '{
    30'(64'd4294967296 / 64'd6),   30'(64'd4294967296 / 64'd20),
    30'(64'd4294967296 / 64'd42),  30'(64'd4294967296 / 64'd72),
    30'(64'd4294967296 / 64'd110), 30'(64'd4294967296 / 64'd156),
    30'(64'd4294967296 / 64'd210), 30'(64'd4294967296 / 64'd272)
  };

  // register layers in one arcsine cell: angle scale, square, three per term,
  // clamp and multiply, compare
  localparam int CELL_STAGES = 2 + 3 * N_TERMS + 2;

  localparam logic [16:0] DIST_MAX = 17'd131071;

  // how the final stage forms an angle
  typedef enum logic [1:0] {
    SEL_SEARCH,
    SEL_ZERO,
    SEL_CLIP,
    SEL_FULL
  } asin_sel_t;

  typedef struct packed {
    logic      neg;
    asin_sel_t sel;
  } ang_flag_t;

endpackage

### sv/fpae_if.sv
// ----------------------------------------------------------------------------
// fpae_if: channel interfaces of the face pose angle estimator
// Landmark channel into the block and pose channel out of it, valid/ready.
// ----------------------------------------------------------------------------
interface fpae_in_if import fpae_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] nose_x;
  logic [COORD_BITS-1:0] nose_y;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [COORD_BITS-1:0] box_width;
  logic [COORD_BITS-1:0] box_height;
  logic [COORD_BITS-1:0] left_eye_x;
  logic [COORD_BITS-1:0] left_eye_y;
  logic [COORD_BITS-1:0] right_eye_x;
  logic [COORD_BITS-1:0] right_eye_y;

  modport source (
    output valid, nose_x, nose_y, box_x, box_y, box_width, box_height,
           left_eye_x, left_eye_y, right_eye_x, right_eye_y,
    input  ready
  );
  modport sink (
    input  valid, nose_x, nose_y, box_x, box_y, box_width, box_height,
           left_eye_x, left_eye_y, right_eye_x, right_eye_y,
    output ready
  );
endinterface

interface fpae_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_deg;
  logic signed [15:0] pitch_deg;
  logic [16:0]        eye_distance;
  logic               yaw_clipped;
  logic               pitch_clipped;

  modport source (
    output valid, yaw_deg, pitch_deg, eye_distance, yaw_clipped, pitch_clipped,
    input  ready
  );
  modport sink (
    input  valid, yaw_deg, pitch_deg, eye_distance, yaw_clipped, pitch_clipped,
    output ready
  );
endinterface

### sv/face_pose_angle_estimator_unit.sv
// ----------------------------------------------------------------------------
// face_pose_angle_estimator_unit: yaw, pitch and eye distance of a face
// Two chains of arcsine cells and a chain of square root cells, one flow.
// ----------------------------------------------------------------------------
// Usage:
//   lmk  (sink)   one transaction per face: box, nose and both eye landmarks.
//   pose (source) one transaction per face: yaw and pitch in signed Q8.8
//                 degrees with clip flags, eye distance in unsigned Q13.4.
//   Results leave in the order the faces arrived.
// Throughput: one face per cycle, sustained while the output is not stalled.
// Depth: set by the arcsine search, 16 cells, one per code bit, each a
//   28 layer pipeline evaluating a 9 term sine series.
// Flow control: the whole pipeline advances together whenever the output
//   register is empty or being taken. A one entry skid register on the
//   input takes one more face while the output is stalled; lmk.ready is the
//   skid register being empty, and is low while rst is high.
// Reset: rst clears all valid flags and the skid register; no result is
//   in flight afterwards. There are no configuration registers.
// ----------------------------------------------------------------------------
module face_pose_angle_estimator_unit import fpae_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fpae_in_if.sink      lmk,
  fpae_out_if.source   pose
);

  localparam int CB    = COORD_BITS;
  localparam int AW    = CB + 3;
  localparam int NW    = CB + 5;
  localparam int RW    = CB + 5;
  localparam int VW    = 2 * CB + 9;
  localparam int FW    = 10 * CB;
  localparam int CHAIN = H_BITS * CELL_STAGES;
  localparam int LAT   = CHAIN + 2;
  localparam int DL    = CHAIN - 3 - RW;

  logic adv;
  logic [LAT-1:0] vld;

  // input skid register
  logic          skid_full;
  logic [FW-1:0] skid_vec;
  logic [FW-1:0] in_vec;
  logic [FW-1:0] src_vec;
  logic          src_valid;

  assign in_vec = {lmk.nose_x, lmk.nose_y, lmk.box_x, lmk.box_y, lmk.box_width,
                   lmk.box_height, lmk.left_eye_x, lmk.left_eye_y,
                   lmk.right_eye_x, lmk.right_eye_y};

  assign adv       = !vld[LAT-1] || pose.ready;
  assign lmk.ready = !skid_full && !rst;
  assign src_valid = skid_full || lmk.valid;
  assign src_vec   = skid_full ? skid_vec : in_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (lmk.valid && !skid_full) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && !skid_full) begin
      skid_vec <= in_vec;
    end
  end

  // valid flags of every layer
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], src_valid};
    end
  end

  // front stage: arcsine ratios, special cases, eye deltas
  logic signed [NW-1:0] nx_s, ny_s, bx_s, by_s, bw_s, bh_s, num_y, num_p;
  logic [NW-1:0]        abs_y, abs_p;
  logic [AW-1:0]        a0 [2];
  logic [AW-1:0]        d0 [2];
  ang_flag_t            f0 [2];
  logic signed [CB:0]   ex, ey;
  logic [CB-1:0]        dxa_n, dya_n;

  assign nx_s  = NW'(src_vec[9*CB +: CB]);
  assign ny_s  = NW'(src_vec[8*CB +: CB]);
  assign bx_s  = NW'(src_vec[7*CB +: CB]);
  assign by_s  = NW'(src_vec[6*CB +: CB]);
  assign bw_s  = NW'(src_vec[5*CB +: CB]);
  assign bh_s  = NW'(src_vec[4*CB +: CB]);
  assign num_y = ((nx_s - bx_s) <<< 1) - bw_s;
  assign num_p = ((ny_s - by_s) <<< 2) + (ny_s - by_s) - (bh_s <<< 1) - bh_s;
  assign abs_y = num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
  assign abs_p = num_p[NW-1] ? NW'(-num_p) : NW'(num_p);

  assign ex    = (CB+1)'(src_vec[3*CB +: CB]) - (CB+1)'(src_vec[CB +: CB]);
  assign ey    = (CB+1)'(src_vec[2*CB +: CB]) - (CB+1)'(src_vec[0 +: CB]);
  assign dxa_n = ex[CB] ? CB'(-ex) : CB'(ex);
  assign dya_n = ey[CB] ? CB'(-ey) : CB'(ey);

  logic [AW-1:0] a_n [2];
  logic [AW-1:0] d_n [2];
  logic          neg_n [2];
  ang_flag_t     f_n [2];

  always_comb begin
    a_n[0]   = AW'(abs_y);
    a_n[1]   = AW'(abs_p);
    d_n[0]   = AW'(src_vec[5*CB +: CB]);
    d_n[1]   = (AW'(src_vec[4*CB +: CB]) << 1) + AW'(src_vec[4*CB +: CB]);
    neg_n[0] = num_y[NW-1];
    neg_n[1] = num_p[NW-1];
    for (int g = 0; g < 2; g++) begin
      f_n[g].neg = neg_n[g];
      priority if (d_n[g] == '0) begin
        f_n[g].sel = SEL_ZERO;
      end else if (a_n[g] > d_n[g]) begin
        f_n[g].sel = SEL_CLIP;
      end else if (a_n[g] == d_n[g]) begin
        f_n[g].sel = SEL_FULL;
      end else begin
        f_n[g].sel = SEL_SEARCH;
      end
    end
  end

  logic [CB-1:0] dxa, dya;

  always_ff @(posedge clk) begin
    if (adv) begin
      a0[0] <= a_n[0];
      a0[1] <= a_n[1];
      d0[0] <= d_n[0];
      d0[1] <= d_n[1];
      f0[0] <= f_n[0];
      f0[1] <= f_n[1];
      dxa   <= dxa_n;
      dya   <= dya_n;
    end
  end

  // arcsine cell chains, one per angle, plus the flags alongside them
  logic [AW-1:0]     ca [2][H_BITS+1];
  logic [AW-1:0]     cd [2][H_BITS+1];
  logic [H_BITS-1:0] ch [2][H_BITS+1];
  ang_flag_t         fl [2][CHAIN];

  for (genvar g = 0; g < 2; g++) begin : g_ang
    assign ca[g][0] = a0[g];
    assign cd[g][0] = d0[g];
    assign ch[g][0] = '0;

    for (genvar i = 0; i < H_BITS; i++) begin : g_cell
      fpae_asin_cell #(
        .AW  (AW),
        .BIT (H_BITS - 1 - i)
      ) u_cell (
        .clk   (clk),
        .en    (adv),
        .a_in  (ca[g][i]),
        .d_in  (cd[g][i]),
        .h_in  (ch[g][i]),
        .a_out (ca[g][i+1]),
        .d_out (cd[g][i+1]),
        .h_out (ch[g][i+1])
      );
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        fl[g][0] <= f0[g];
        for (int k = 1; k < CHAIN; k++) begin
          fl[g][k] <= fl[g][k-1];
        end
      end
    end
  end

  // eye distance: squares, sum, square root cells, rounding, delay
  logic [2*CB-1:0] sqx, sqy;
  logic [VW-1:0]   v_r;
  logic [RW-1:0]   sr [RW+1];
  logic [VW-1:0]   sm [RW+1];
  logic [16:0]     dist_r;
  logic [16:0]     dl [DL];
  logic [RW:0]     r_rnd;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx <= (2*CB)'(dxa) * (2*CB)'(dxa);
      sqy <= (2*CB)'(dya) * (2*CB)'(dya);
      v_r <= (VW'(sqx) + VW'(sqy)) << 8;
    end
  end

  assign sr[0] = '0;
  assign sm[0] = v_r;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    fpae_sqrt_cell #(
      .RW (RW),
      .VW (VW),
      .B  (RW - 1 - i)
    ) u_cell (
      .clk     (clk),
      .en      (adv),
      .r_in    (sr[i]),
      .rem_in  (sm[i]),
      .r_out   (sr[i+1]),
      .rem_out (sm[i+1])
    );
  end

  // round to nearest, then saturate
  assign r_rnd = ((RW+1)'(sm[RW]) > (RW+1)'(sr[RW])) ? (RW+1)'(sr[RW]) + 1'b1
                                                     : (RW+1)'(sr[RW]);

  always_ff @(posedge clk) begin
    if (adv) begin
      dist_r <= (r_rnd > (RW+1)'(DIST_MAX)) ? DIST_MAX : 17'(r_rnd);
      dl[0]  <= dist_r;
      for (int k = 1; k < DL; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  // final stage: form the angles
  logic signed [15:0] ang_n  [2];
  logic               clip_n [2];
  logic [16:0]        hm;
  logic [15:0]        mag;

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      hm  = 17'(ch[g][H_BITS]) + 17'd1;
      mag = hm[16:1];
      unique case (fl[g][CHAIN-1].sel)
        SEL_ZERO: begin
          mag       = '0;
          clip_n[g] = 1'b1;
        end
        SEL_CLIP: begin
          mag       = ANGLE_MAX;
          clip_n[g] = 1'b1;
        end
        SEL_FULL: begin
          mag       = ANGLE_MAX;
          clip_n[g] = 1'b0;
        end
        default: begin
          clip_n[g] = 1'b0;
        end
      endcase
      ang_n[g] = fl[g][CHAIN-1].neg ? $signed(-mag) : $signed(mag);
    end
  end

  logic signed [15:0] yaw_r, pitch_r;
  logic [16:0]        eye_r;
  logic               yclip_r, pclip_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      yaw_r   <= ang_n[0];
      pitch_r <= ang_n[1];
      yclip_r <= clip_n[0];
      pclip_r <= clip_n[1];
      eye_r   <= dl[DL-1];
    end
  end

  assign pose.valid         = vld[LAT-1];
  assign pose.yaw_deg       = yaw_r;
  assign pose.pitch_deg     = pitch_r;
  assign pose.eye_distance  = eye_r;
  assign pose.yaw_clipped   = yclip_r;
  assign pose.pitch_clipped = pclip_r;

endmodule

### sv/fpae_asin_cell.sv
// ----------------------------------------------------------------------------
// fpae_asin_cell: one bit of the arcsine search
// Evaluates the sine series at the trial code; keeps the bit when the code is
// at most HALF_MAX and sine * denominator is at most the scaled numerator.
// ----------------------------------------------------------------------------
module fpae_asin_cell import fpae_pkg::*; #(
  parameter int AW  = 15,
  parameter int BIT = 15
) (
  input  logic              clk,
  input  logic              en,
  input  logic [AW-1:0]     a_in,
  input  logic [AW-1:0]     d_in,
  input  logic [H_BITS-1:0] h_in,
  output logic [AW-1:0]     a_out,
  output logic [AW-1:0]     d_out,
  output logic [H_BITS-1:0] h_out
);

  localparam int CW = 2 * AW + H_BITS;
  localparam int NS = 3 * N_TERMS + 3;
  localparam int SW = 34;
  localparam int PW = 31 + AW;

  // {a, d, h} travels alongside the series
  logic [CW-1:0] ctx [NS];

  logic [H_BITS-1:0] t_in;
  logic [47:0]       xm;
  logic [30:0]       x_0;
  logic [61:0]       x2m;

  logic [30:0]           term_c [N_TERMS+1];
  logic [31:0]           x2_c   [N_TERMS+1];
  logic signed [SW-1:0]  sum_c  [N_TERMS+1];

  logic [31:0]          p_a   [N_TERMS];
  logic [31:0]          x2_a  [N_TERMS];
  logic signed [SW-1:0] sum_a [N_TERMS];
  logic [31:0]          p_b   [N_TERMS];
  logic [29:0]          q0_b  [N_TERMS];
  logic [31:0]          x2_b  [N_TERMS];
  logic signed [SW-1:0] sum_b [N_TERMS];

  logic [30:0]       s_cl;
  logic [PW-1:0]     prod;
  logic [AW-1:0]     a_f;
  logic [AW-1:0]     d_f;
  logic [H_BITS-1:0] h_f;
  logic [H_BITS-1:0] t_f;
  logic              keep;

  // trial code scaled to radians
  assign t_in = h_in | (H_BITS'(1) << BIT);
  assign xm   = 48'(t_in) * 48'(RAD_PER_HALF);
  assign x2m  = 62'(x_0) * 62'(x_0);

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0]   <= {a_in, d_in, h_in};
      x_0      <= xm[46:16];
      ctx[1]   <= ctx[0];
      x2_c[0]  <= x2m[61:30];
      term_c[0] <= x_0;
      sum_c[0] <= $signed(SW'(x_0));
    end
  end

  // one series term per three layers: multiply, reciprocal, correct and add
  for (genvar j = 0; j < N_TERMS; j++) begin : g_term
    logic [62:0] pm;
    logic [61:0] qm;
    logic [31:0] cm;
    logic [31:0] rr;
    logic [30:0] q;

    assign pm = 63'(term_c[j]) * 63'(x2_c[j]);
    assign qm = 62'(p_a[j]) * 62'(TERM_RECIP[j]);
    assign cm = 32'(q0_b[j]) * 32'(TERM_DIV[j]);
    assign rr = p_b[j] - cm;
    assign q  = (rr >= 32'(TERM_DIV[j])) ? 31'(q0_b[j]) + 31'd1 : 31'(q0_b[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        p_a[j]       <= pm[61:30];
        x2_a[j]      <= x2_c[j];
        sum_a[j]     <= sum_c[j];
        ctx[3*j+2]   <= ctx[3*j+1];
        p_b[j]       <= p_a[j];
        q0_b[j]      <= qm[61:32];
        x2_b[j]      <= x2_a[j];
        sum_b[j]     <= sum_a[j];
        ctx[3*j+3]   <= ctx[3*j+2];
        term_c[j+1]  <= q;
        x2_c[j+1]    <= x2_b[j];
        ctx[3*j+4]   <= ctx[3*j+3];
        if ((j % 2) == 0) begin
          sum_c[j+1] <= sum_b[j] - $signed(SW'(q));
        end else begin
          sum_c[j+1] <= sum_b[j] + $signed(SW'(q));
        end
      end
    end
  end

  // clamp the sine to 0..1 and scale by the denominator
  always_comb begin
    if (sum_c[N_TERMS][SW-1]) begin
      s_cl = '0;
    end else if (sum_c[N_TERMS] > $signed(SW'(ONE_Q30))) begin
      s_cl = ONE_Q30;
    end else begin
      s_cl = sum_c[N_TERMS][30:0];
    end
  end

  assign {a_f, d_f, h_f} = ctx[NS-1];
  assign t_f  = h_f | (H_BITS'(1) << BIT);
  assign keep = (t_f <= HALF_MAX) && (prod <= PW'({a_f, 30'b0}));

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= PW'(s_cl) * PW'(ctx[NS-2][H_BITS +: AW]);
      ctx[NS-1] <= ctx[NS-2];
      a_out     <= a_f;
      d_out     <= d_f;
      h_out     <= keep ? t_f : h_f;
    end
  end

endmodule

### sv/fpae_sqrt_cell.sv
// ----------------------------------------------------------------------------
// fpae_sqrt_cell: one bit of the restoring square root
// Tries to set root bit B and takes (2r*2^B + 2^2B) off the remainder.
// ----------------------------------------------------------------------------
module fpae_sqrt_cell import fpae_pkg::*; #(
  parameter int RW = 17,
  parameter int VW = 33,
  parameter int B  = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] r_in,
  input  logic [VW-1:0] rem_in,
  output logic [RW-1:0] r_out,
  output logic [VW-1:0] rem_out
);

  localparam int EW = 2 * RW + 1;

  logic [EW-1:0] e;
  logic [EW-1:0] rx;

  assign e  = (EW'(r_in) << (B + 1)) | (EW'(1) << (2 * B));
  assign rx = EW'(rem_in);

  always_ff @(posedge clk) begin
    if (en) begin
      if (e <= rx) begin
        r_out   <= r_in | (RW'(1) << B);
        rem_out <= VW'(rx - e);
      end else begin
        r_out   <= r_in;
        rem_out <= rem_in;
      end
    end
  end

endmodule

### sv/fpae_checker.sv
// ----------------------------------------------------------------------------
// fpae_checker: port level checks of the face pose angle estimator
// Angle ranges, clipped values and output hold under stall.
// ----------------------------------------------------------------------------
module fpae_checker import fpae_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               pose_valid,
  input logic               pose_ready,
  input logic signed [15:0] yaw_deg,
  input logic signed [15:0] pitch_deg,
  input logic [16:0]        eye_distance,
  input logic               yaw_clipped,
  input logic               pitch_clipped
);

  localparam logic signed [15:0] AMAX = $signed(ANGLE_MAX);

  // a clipped yaw is zero or full scale
  a_yaw_clip: assert property (@(posedge clk) disable iff (rst)
    pose_valid && yaw_clipped |->
      yaw_deg == 16'sd0 || yaw_deg == AMAX || yaw_deg == -AMAX)
    else $error("clipped yaw not at zero or full scale");

  // a clipped pitch is zero or full scale
  a_pitch_clip: assert property (@(posedge clk) disable iff (rst)
    pose_valid && pitch_clipped |->
      pitch_deg == 16'sd0 || pitch_deg == AMAX || pitch_deg == -AMAX)
    else $error("clipped pitch not at zero or full scale");

  // angles stay within ninety degrees
  a_range: assert property (@(posedge clk) disable iff (rst)
    pose_valid |-> yaw_deg <= AMAX && yaw_deg >= -AMAX &&
                   pitch_deg <= AMAX && pitch_deg >= -AMAX)
    else $error("angle beyond ninety degrees");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pose_valid && !pose_ready |=> pose_valid && $stable(yaw_deg) &&
      $stable(pitch_deg) && $stable(eye_distance))
    else $error("stalled result changed");

endmodule

bind face_pose_angle_estimator_unit fpae_checker u_fpae_checker (
  .clk           (clk),
  .rst           (rst),
  .pose_valid    (pose.valid),
  .pose_ready    (pose.ready),
  .yaw_deg       (pose.yaw_deg),
  .pitch_deg     (pose.pitch_deg),
  .eye_distance  (pose.eye_distance),
  .yaw_clipped   (pose.yaw_clipped),
  .pitch_clipped (pose.pitch_clipped)
);
